// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer package
// Payload types, request and event codes, state encoding and helpers.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int unsigned TotalBytes = 12;
  localparam int unsigned IdBytes    = 12;
  localparam int unsigned IdW        = 8 * TotalBytes;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgW-1:0] PresentDebounceReset = 16'd500;
  localparam logic [CfgW-1:0] AbsentDebounceReset  = 16'd2000;

  localparam logic [CfgIdxW-1:0] CFG_PRESENT_DEBOUNCE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ABSENT_DEBOUNCE  = 1'd1;

  localparam logic [1:0] REQ_TAG_SEEN   = 2'd0;
  localparam logic [1:0] REQ_NO_TAG     = 2'd1;
  localparam logic [1:0] REQ_SOFT_RESET = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PLACED  = 2'd1;
  localparam logic [1:0] EV_REMOVED = 2'd2;

  localparam logic [1:0] ST_IDLE       = 2'd0;
  localparam logic [1:0] ST_CONFIRMING = 2'd1;
  localparam logic [1:0] ST_PRESENT    = 2'd2;
  localparam logic [1:0] ST_REMOVING   = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'b0001,
    MODE_CONFIRMING = 4'b0010,
    MODE_PRESENT    = 4'b0100,
    MODE_REMOVING   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic               tag_eligible;
    logic [31:0]        id_high;
    logic [63:0]        id_low;
    logic [3:0]         id_len;
    logic signed [7:0]  strength_dbm;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         fsm_state;
    logic [31:0]        out_id_high;
    logic [63:0]        out_id_low;
    logic [3:0]         out_id_len;
    logic signed [7:0]  out_strength_dbm;
    logic [31:0]        play_duration_ms;
    logic [31:0]        placed_total;
    logic [31:0]        removed_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        id_high;
    logic [63:0]        id_low;
    logic [3:0]         id_len;
    logic signed [7:0]  strength;
  } tag_t;

  // Saturates the length and zeroes every ID byte at or beyond it.
  function automatic in_item_t norm_item(in_item_t raw);
    in_item_t       r;
    logic [IdW-1:0] id;
    logic [3:0]     len;
    r   = raw;
    len = (raw.id_len > 4'(IdBytes)) ? 4'(IdBytes) : raw.id_len;
    id  = {raw.id_high, raw.id_low};
    for (int i = 0; i < TotalBytes; i++) begin
      if (4'(i) >= len) begin
        id[IdW-1-8*i -: 8] = 8'h00;
      end
    end
    r.id_len  = len;
    r.id_high = id[IdW-1 -: 32];
    r.id_low  = id[63:0];
    return r;
  endfunction

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:       c = ST_IDLE;
      MODE_CONFIRMING: c = ST_CONFIRMING;
      MODE_PRESENT:    c = ST_PRESENT;
      MODE_REMOVING:   c = ST_REMOVING;
      default:         c = ST_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/tag_presence_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer
// Debounces RFID poll outcomes into tag placed and tag removed events.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_ready   in_data  (tpd_pkg::in_item_t)
//  out      output     out_valid / out_ready out_data (tpd_pkg::out_item_t)
//  cfg      input      cfg_we                cfg_index, cfg_wdata
//
// A beat is captured in the input register at the edge that accepts it, and its
// result is loaded into the output register once that register has space; one
// beat a cycle is sustained while the output is not stalled, as the whole state
// update fits between the two registers.
// Reset is synchronous and leaves both registers empty and the debounce state idle.
// A stall on the output holds the result register and then the input register.
module tag_presence_debouncer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tpd_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tpd_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [tpd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tpd_pkg::CfgW-1:0]    cfg_wdata
);
  import tpd_pkg::*;

  logic      item_valid;
  in_item_t  item;
  out_item_t result;
  logic      space;
  logic      fire;

  assign fire = item_valid && space;

  tpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (space),
    .item_valid (item_valid),
    .item       (item)
  );

  tpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  tpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/tpd_in_stage.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer input stage
// Registers each input beat with its ID masked to its saturated length.
// ----------------------------------------------------------------------------
module tpd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpd_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output tpd_pkg::in_item_t item
);
  import tpd_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= norm_item(in_data);
    end
  end

endmodule

// ----- sv/tpd_core.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer core
// Holds the debounce state and registers, and forms the result of one beat.
// ----------------------------------------------------------------------------
module tpd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tpd_pkg::CfgW-1:0]     cfg_wdata,
  input  logic                         fire,
  input  tpd_pkg::in_item_t            item,
  output tpd_pkg::out_item_t           result
);
  import tpd_pkg::*;

  logic [CfgW-1:0] present_debounce_ms;
  logic [CfgW-1:0] absent_debounce_ms;

  mode_t       mode, mode_next;
  tag_t        current, current_next;
  tag_t        pending, pending_next;
  logic [31:0] entered_ms, entered_ms_next;
  logic [31:0] placed_ms, placed_ms_next;
  logic [31:0] placed_count, placed_count_next;
  logic [31:0] removed_count, removed_count_next;

  tag_t        seen;
  logic        same_pending, same_current;
  logic        present_due, absent_due;
  logic [31:0] since_entered;
  logic [1:0]  ev;
  logic [31:0] dur;
  tag_t        shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      present_debounce_ms <= PresentDebounceReset;
      absent_debounce_ms  <= AbsentDebounceReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESENT_DEBOUNCE: present_debounce_ms <= cfg_wdata;
        CFG_ABSENT_DEBOUNCE:  absent_debounce_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign seen = '{id_high: item.id_high, id_low: item.id_low,
                  id_len: item.id_len, strength: item.strength_dbm};

  // Tags match on length and bytes; strength is not part of identity.
  assign same_pending = (seen.id_len == pending.id_len) &&
                        (seen.id_high == pending.id_high) &&
                        (seen.id_low == pending.id_low);
  assign same_current = (seen.id_len == current.id_len) &&
                        (seen.id_high == current.id_high) &&
                        (seen.id_low == current.id_low);

  assign since_entered = item.now_ms - entered_ms;
  assign present_due   = since_entered >= {16'd0, present_debounce_ms};
  assign absent_due    = since_entered >= {16'd0, absent_debounce_ms};

  always_comb begin
    mode_next          = mode;
    current_next       = current;
    pending_next       = pending;
    entered_ms_next    = entered_ms;
    placed_ms_next     = placed_ms;
    placed_count_next  = placed_count;
    removed_count_next = removed_count;
    ev                 = EV_NONE;
    dur                = 32'd0;
    case (item.req_type)
      REQ_TAG_SEEN: begin
        if (item.tag_eligible) begin
          case (mode)
            MODE_IDLE: begin
              pending_next    = seen;
              entered_ms_next = item.now_ms;
              mode_next       = MODE_CONFIRMING;
            end
            MODE_CONFIRMING: begin
              if (same_pending && present_due) begin
                current_next      = pending;
                placed_ms_next    = item.now_ms;
                pending_next      = '0;
                mode_next         = MODE_PRESENT;
                placed_count_next = placed_count + 32'd1;
                ev                = EV_PLACED;
              end else if (same_pending) begin
                pending_next.strength = seen.strength;
              end else begin
                pending_next    = seen;
                entered_ms_next = item.now_ms;
              end
            end
            MODE_PRESENT: begin
              if (same_current) begin
                current_next.strength = seen.strength;
              end
            end
            MODE_REMOVING: begin
              if (same_current) begin
                current_next.strength = seen.strength;
                mode_next             = MODE_PRESENT;
              end
            end
            default: ;
          endcase
        end
      end
      REQ_NO_TAG: begin
        case (mode)
          MODE_CONFIRMING: begin
            pending_next = '0;
            mode_next    = MODE_IDLE;
          end
          MODE_PRESENT: begin
            entered_ms_next = item.now_ms;
            mode_next       = MODE_REMOVING;
          end
          MODE_REMOVING: begin
            if (absent_due) begin
              dur                = item.now_ms - placed_ms;
              ev                 = EV_REMOVED;
              removed_count_next = removed_count + 32'd1;
              current_next       = '0;
              placed_ms_next     = 32'd0;
              mode_next          = MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      REQ_SOFT_RESET: begin
        mode_next       = MODE_IDLE;
        current_next    = '0;
        pending_next    = '0;
        entered_ms_next = 32'd0;
        placed_ms_next  = 32'd0;
      end
      default: ;
    endcase
  end

  // A removal reports the tag that has just left; otherwise the tag held after the beat.
  assign shown = (ev == EV_REMOVED) ? current : current_next;

  assign result = '{
    event_kind:       ev,
    fsm_state:        mode_code(mode_next),
    out_id_high:      shown.id_high,
    out_id_low:       shown.id_low,
    out_id_len:       shown.id_len,
    out_strength_dbm: shown.strength,
    play_duration_ms: dur,
    placed_total:     placed_count_next,
    removed_total:    removed_count_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      current       <= '0;
      pending       <= '0;
      entered_ms    <= 32'd0;
      placed_ms     <= 32'd0;
      placed_count  <= 32'd0;
      removed_count <= 32'd0;
    end else if (fire) begin
      mode          <= mode_next;
      current       <= current_next;
      pending       <= pending_next;
      entered_ms    <= entered_ms_next;
      placed_ms     <= placed_ms_next;
      placed_count  <= placed_count_next;
      removed_count <= removed_count_next;
    end
  end

endmodule

// ----- sv/tpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer output stage
// Result register on the output channel; offers space whenever it can load.
// ----------------------------------------------------------------------------
module tpd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tpd_pkg::out_item_t result,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output tpd_pkg::out_item_t out_data
);
  import tpd_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      out_data <= result;
    end
  end

endmodule

// ----- sv/tpd_checker.sv -----
// ----------------------------------------------------------------------------
// Tag presence debouncer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input tpd_pkg::out_item_t out_data
);
  import tpd_pkg::*;

  logic placed_beat;
  logic removed_beat;
  logic plain_beat;

  assign placed_beat  = out_valid && (out_data.event_kind == EV_PLACED);
  assign removed_beat = out_valid && (out_data.event_kind == EV_REMOVED);
  assign plain_beat   = out_valid && (out_data.event_kind != EV_REMOVED);

  // A stalled result beat must hold.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // A placement always leaves the tag present.
  `ASSERT_SAME(a_placed_present, clk, rst, placed_beat, out_data.fsm_state == ST_PRESENT)

  // A removal always returns to idle.
  `ASSERT_SAME(a_removed_idle, clk, rst, removed_beat, out_data.fsm_state == ST_IDLE)

  // Play time is only reported with a removal.
  `ASSERT_SAME(a_duration_zero, clk, rst, plain_beat, out_data.play_duration_ms == 32'd0)

endmodule

bind tag_presence_debouncer_top tpd_checker u_tpd_checker (.*);
